/* src/lowest_free_id_allocator_top_assert.svh */
// Assertion macros for the identifier allocator
`ifndef LOWEST_FREE_ID_ALLOCATOR_TOP_ASSERT_SVH
`define LOWEST_FREE_ID_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset
`define LFIA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define LFIA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/lfia_pkg.sv */
// Package: item types, codes and helpers for the identifier allocator
`timescale 1ns / 1ps

package lfia_pkg;

    localparam int MAX_IDS    = 256;
    localparam int WORD_BITS  = 64;
    localparam int NWORDS     = MAX_IDS / WORD_BITS;
    localparam int ID_W       = 8;
    localparam int CNT_W      = 9;
    localparam int BIT_IDX_W  = $clog2(WORD_BITS);
    localparam int WORD_IDX_W = $clog2(NWORDS);

    localparam logic [CNT_W-1:0] COUNT_LIMIT = CNT_W'(MAX_IDS);

    localparam logic [1:0] KIND_ALLOC   = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_QUERY   = 2'd2;
    localparam logic [1:0] KIND_NOP     = 2'd3;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_FULL     = 2'd1;
    localparam logic [1:0] STATUS_NOT_USED = 2'd2;
    localparam logic [1:0] STATUS_RANGE    = 2'd3;

    typedef logic [WORD_BITS-1:0] word_t;

    typedef struct packed {
        logic [1:0]      kind;
        logic [ID_W-1:0] id;
    } in_item_t;

    typedef struct packed {
        logic [ID_W-1:0]  granted_id;
        logic [1:0]       status;
        logic             in_use;
        logic [CNT_W-1:0] count_in_use;
    } out_item_t;

    function automatic logic [BIT_IDX_W-1:0] lowest_set(input word_t w);
        logic [BIT_IDX_W-1:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (w[i])
            begin
                idx = BIT_IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

/* src/lowest_free_id_allocator_top.sv */
// Identifier allocator: bitmap, hint, count and the scanning sequencer
`timescale 1ns / 1ps

// Command-style allocator of identifiers 0..255 held in a bitmap of four 64-bit words.
// An item is taken when start is high and busy is low; its result appears on result
// for exactly one cycle with done high and must be taken then; result keeps it until the next execute.
// Release, query, no-op and any allocate that needs no search pass from idle through
// the execute state back to idle. An allocate below the limit while a release has left
// a hint scans from the hint word one word per cycle through the single word read and
// find-first-zero unit up to the last word, and reports full if it finds no free bit;
// with the hint past the last identifier it reports full without a scan.
// Writing cfg_data with cfg_we sets the limit on identifiers in use (reset 256).
module lowest_free_id_allocator_top
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  lfia_pkg::in_item_t      cmd,
    output logic                    done,
    output lfia_pkg::out_item_t     result,
    input  logic                    cfg_we,
    input  logic [lfia_pkg::CNT_W-1:0] cfg_data
);
    import lfia_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_SCAN} state_t;

    state_t                state_reg, state_next;
    word_t                 used_map_reg [NWORDS];
    logic [CNT_W-1:0]      used_count_reg, used_count_next;
    logic [CNT_W-1:0]      free_hint_reg, free_hint_next;
    logic                  hint_valid_reg, hint_valid_next;
    logic [CNT_W-1:0]      max_ids_reg, max_ids_next;
    logic [1:0]            kind_reg, kind_next;
    logic [ID_W-1:0]       id_reg, id_next;
    logic [WORD_IDX_W-1:0] scan_w_reg, scan_w_next;
    logic                  first_reg, first_next;
    logic                  done_reg, done_next;
    out_item_t             result_reg, result_next;

    logic                  map_we;
    logic [WORD_IDX_W-1:0] map_widx;
    word_t                 map_wdata;

    logic [WORD_IDX_W-1:0] rd_idx;
    logic [BIT_IDX_W-1:0]  rd_bit;
    word_t                 rd_word;
    word_t                 scan_mask;
    word_t                 scan_cand;
    logic [BIT_IDX_W-1:0]  scan_bit;
    logic [ID_W-1:0]       scan_id;
    logic [CNT_W-1:0]      id_wide;
    logic [CNT_W-1:0]      count_dec;

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    assign id_wide   = {1'b0, id_reg};
    assign count_dec = used_count_reg - CNT_W'(1);

    always_comb
    begin
        if (state_reg == S_SCAN)
        begin
            rd_idx = scan_w_reg;
            rd_bit = '0;
        end
        else if (kind_reg == KIND_ALLOC)
        begin
            rd_idx = used_count_reg[ID_W-1:BIT_IDX_W];
            rd_bit = used_count_reg[BIT_IDX_W-1:0];
        end
        else
        begin
            rd_idx = id_reg[ID_W-1:BIT_IDX_W];
            rd_bit = id_reg[BIT_IDX_W-1:0];
        end
    end

    assign rd_word   = used_map_reg[rd_idx];
    assign scan_mask = first_reg ? ({WORD_BITS{1'b1}} << free_hint_reg[BIT_IDX_W-1:0])
                                 : {WORD_BITS{1'b1}};
    assign scan_cand = ~rd_word & scan_mask;
    assign scan_bit  = lowest_set(scan_cand);
    assign scan_id   = {scan_w_reg, scan_bit};

    always_comb
    begin
        state_next      = state_reg;
        used_count_next = used_count_reg;
        free_hint_next  = free_hint_reg;
        hint_valid_next = hint_valid_reg;
        max_ids_next    = cfg_we ? cfg_data : max_ids_reg;
        kind_next       = kind_reg;
        id_next         = id_reg;
        scan_w_next     = scan_w_reg;
        first_next      = first_reg;
        done_next       = 1'b0;
        result_next     = result_reg;
        map_we          = 1'b0;
        map_widx        = rd_idx;
        map_wdata       = rd_word;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    kind_next  = cmd.kind;
                    id_next    = cmd.id;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                result_next = '0;
                done_next   = 1'b1;
                state_next  = S_IDLE;
                unique case (kind_reg)
                    KIND_ALLOC:
                    begin
                        if ((used_count_reg >= max_ids_reg) ||
                            (used_count_reg >= COUNT_LIMIT))
                        begin
                            result_next.status = STATUS_FULL;
                        end
                        else if (!hint_valid_reg)
                        begin
                            map_we                 = 1'b1;
                            map_wdata              = rd_word | (word_t'(1) << rd_bit);
                            result_next.granted_id = used_count_reg[ID_W-1:0];
                            used_count_next        = used_count_reg + CNT_W'(1);
                        end
                        else if (free_hint_reg >= COUNT_LIMIT)
                        begin
                            result_next.status = STATUS_FULL;
                        end
                        else
                        begin
                            done_next   = 1'b0;
                            state_next  = S_SCAN;
                            scan_w_next = free_hint_reg[ID_W-1:BIT_IDX_W];
                            first_next  = 1'b1;
                        end
                    end
                    KIND_RELEASE:
                    begin
                        if (id_wide >= COUNT_LIMIT)
                        begin
                            result_next.status = STATUS_RANGE;
                        end
                        else if (!rd_word[rd_bit])
                        begin
                            result_next.status = STATUS_NOT_USED;
                        end
                        else
                        begin
                            map_we          = 1'b1;
                            map_wdata       = rd_word & ~(word_t'(1) << rd_bit);
                            used_count_next = count_dec;
                            if ((!hint_valid_reg && (id_wide < count_dec)) ||
                                (hint_valid_reg && (id_wide < free_hint_reg)))
                            begin
                                free_hint_next  = id_wide;
                                hint_valid_next = 1'b1;
                            end
                        end
                    end
                    KIND_QUERY:
                    begin
                        if (id_wide >= COUNT_LIMIT)
                        begin
                            result_next.status = STATUS_RANGE;
                        end
                        else
                        begin
                            result_next.in_use = rd_word[rd_bit];
                        end
                    end
                    KIND_NOP:
                    begin
                        result_next.status = STATUS_OK;
                    end
                    default:
                    begin
                        result_next.status = STATUS_OK;
                    end
                endcase
            end
            S_SCAN:
            begin
                first_next = 1'b0;
                if (|scan_cand)
                begin
                    map_we                 = 1'b1;
                    map_wdata              = rd_word | (word_t'(1) << scan_bit);
                    result_next.granted_id = scan_id;
                    used_count_next        = used_count_reg + CNT_W'(1);
                    if ({1'b0, scan_id} == used_count_reg)
                    begin
                        hint_valid_next = 1'b0;
                        free_hint_next  = '0;
                    end
                    else
                    begin
                        free_hint_next = {1'b0, scan_id} + CNT_W'(1);
                    end
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (scan_w_reg == WORD_IDX_W'(NWORDS - 1))
                begin
                    result_next.status = STATUS_FULL;
                    done_next          = 1'b1;
                    state_next         = S_IDLE;
                end
                else
                begin
                    scan_w_next = scan_w_reg + WORD_IDX_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (done_next)
        begin
            result_next.count_in_use = used_count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            used_count_reg <= '0;
            free_hint_reg  <= '0;
            hint_valid_reg <= 1'b0;
            max_ids_reg    <= COUNT_LIMIT;
            kind_reg       <= KIND_NOP;
            id_reg         <= '0;
            scan_w_reg     <= '0;
            first_reg      <= 1'b0;
            done_reg       <= 1'b0;
            result_reg     <= '0;
            for (int w = 0; w < NWORDS; w++)
            begin
                used_map_reg[w] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            used_count_reg <= used_count_next;
            free_hint_reg  <= free_hint_next;
            hint_valid_reg <= hint_valid_next;
            max_ids_reg    <= max_ids_next;
            kind_reg       <= kind_next;
            id_reg         <= id_next;
            scan_w_reg     <= scan_w_next;
            first_reg      <= first_next;
            done_reg       <= done_next;
            result_reg     <= result_next;
            if (map_we)
            begin
                used_map_reg[map_widx] <= map_wdata;
            end
        end
    end

`include "lowest_free_id_allocator_top_assert.svh"

    `LFIA_ASSERT_NOW(a_done_when_idle, done_reg, state_reg == S_IDLE, "result strobe while busy")
    `LFIA_ASSERT_NOW(a_count_bounded, 1'b1, used_count_reg <= COUNT_LIMIT, "count above id space")
    `LFIA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "item taken but block not busy")
    `LFIA_ASSERT_NOW(a_scan_has_hint, state_reg == S_SCAN, hint_valid_reg, "scan without a hint")
    `LFIA_ASSERT_NOW(a_count_moves_on_done, used_count_reg != $past(used_count_reg), done_reg, "count changed without a result")

endmodule
